/* hdl/nq_pkg.sv */
`timescale 1ns / 1ps

package nq_pkg;

    // Width of a queen column and of a row number.
    localparam int COL_W = 4;
    // Width of the board size, the search depth and the candidate column.
    localparam int SIZE_W = 5;

    // Control broadcast from the search sequencer to every cell of the stack.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SIZE_W-1:0] depth;
        logic [SIZE_W-1:0] cand;
    } nq_ctrl_t;

endpackage

/* hdl/n_queens_solution_enumerator_core.sv */
`timescale 1ns / 1ps
// Search: each step tries one candidate column, places one queen or backtracks one row,
// so the time to the first result varies with the search.
// Throughput: one item at a time; its results leave at one per cycle while m_ready is high,
// n_eff results for a solution and one for the exhausted result, then the next item is taken.
// Reset: synchronous, active low; the board size returns to 8 and any search is abandoned.
module n_queens_solution_enumerator_core import nq_pkg::*; #(
    parameter int MAX_SIZE = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COL_W-1:0]  m_row_index,
    output logic [COL_W-1:0]  m_queen_column,
    output logic              m_last_row,
    output logic              m_exhausted
);

    localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] board_size_reg, board_size_next;
    logic [SIZE_W-1:0] depth_reg, depth_next;
    logic [SIZE_W-1:0] cand_reg, cand_next;
    logic              started_reg, started_next;
    logic              done_reg, done_next;
    logic              m_valid_reg, m_valid_next;
    logic [COL_W-1:0]  m_row_reg, m_row_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic              m_last_reg, m_last_next;
    logic              m_exh_reg, m_exh_next;

    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] emit_row;
    logic [SIZE_W-1:0] sel_idx;
    logic [COL_W-1:0]  sel_col;
    logic [COL_W-1:0]  top_col;
    logic              conflict;
    logic              push;
    logic              pop;
    logic              req_started;
    logic              req_done;
    logic [SIZE_W-1:0] req_depth;
    nq_ctrl_t          ctrl;

    logic [COL_W-1:0]  cell_col [MAX_SIZE];
    logic              chain [MAX_SIZE+1];

    // Board sizes beyond the stack length saturate.
    assign n_eff = (board_size_reg > MAX_N) ? MAX_N : board_size_reg;

    assign ctrl.push  = push;
    assign ctrl.pop   = pop;
    assign ctrl.depth = depth_reg;
    assign ctrl.cand  = cand_reg;

    // The placement stack: cell 0 holds the most recently placed row.
    assign chain[0] = 1'b0;
    genvar k;
    generate
        for (k = 0; k < MAX_SIZE; k++) begin : g_cell
            logic [COL_W-1:0] prev_c;
            logic [COL_W-1:0] next_c;
            if (k == 0) begin : g_head
                assign prev_c = cand_reg[COL_W-1:0];
            end else begin : g_body
                assign prev_c = cell_col[k-1];
            end
            if (k == MAX_SIZE - 1) begin : g_tail
                assign next_c = cell_col[k];
            end else begin : g_inner
                assign next_c = cell_col[k+1];
            end
            nq_cell #(
                .DIST(k + 1)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .prev_col    (prev_c),
                .next_col    (next_c),
                .conflict_in (chain[k]),
                .col         (cell_col[k]),
                .conflict_out(chain[k+1])
            );
        end
    endgenerate

    assign conflict = chain[MAX_SIZE];
    assign top_col  = cell_col[0];

    // Row r of a full placement sits in cell n-1-r.
    assign emit_row = (state_reg == ST_EMIT) ? ({1'b0, m_row_reg} + 1'b1) : '0;
    assign sel_idx  = n_eff - 1'b1 - emit_row;

    always_comb begin
        sel_col = '0;
        for (int i = 0; i < MAX_SIZE; i++) begin
            if (sel_idx == SIZE_W'(i)) begin
                sel_col = cell_col[i];
            end
        end
    end

    // A restart clears the search before the item is handled.
    assign req_started = started_reg & ~s_restart;
    assign req_done    = done_reg & ~s_restart;
    assign req_depth   = s_restart ? '0 : depth_reg;

    // Search sequencer and result register.
    always_comb begin
        state_next      = state_reg;
        board_size_next = board_size_reg;
        depth_next      = depth_reg;
        cand_next       = cand_reg;
        started_next    = started_reg;
        done_next       = done_reg;
        m_valid_next    = m_valid_reg;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_last_next     = m_last_reg;
        m_exh_next      = m_exh_reg;
        push            = 1'b0;
        pop             = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    started_next = req_started;
                    done_next    = req_done;
                    depth_next   = req_depth;
                    if (n_eff == '0 || req_done) begin
                        state_next   = ST_EMIT;
                        m_valid_next = 1'b1;
                        m_row_next   = '0;
                        m_col_next   = '0;
                        m_last_next  = 1'b1;
                        m_exh_next   = 1'b1;
                    end else if (!req_started) begin
                        started_next = 1'b1;
                        depth_next   = '0;
                        cand_next    = '0;
                        state_next   = ST_SEARCH;
                    end else if (req_depth == '0 || req_depth > n_eff) begin
                        depth_next   = '0;
                        done_next    = 1'b1;
                        state_next   = ST_EMIT;
                        m_valid_next = 1'b1;
                        m_row_next   = '0;
                        m_col_next   = '0;
                        m_last_next  = 1'b1;
                        m_exh_next   = 1'b1;
                    end else begin
                        // Resume: lift the last queen and try the columns after it.
                        pop        = 1'b1;
                        depth_next = req_depth - 1'b1;
                        cand_next  = {1'b0, top_col} + 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (depth_reg >= n_eff) begin
                    state_next   = ST_EMIT;
                    m_valid_next = 1'b1;
                    m_row_next   = '0;
                    m_col_next   = sel_col;
                    m_last_next  = (n_eff == SIZE_W'(1));
                    m_exh_next   = 1'b0;
                end else if (cand_reg < n_eff) begin
                    if (!conflict) begin
                        push       = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        cand_next  = '0;
                    end else begin
                        cand_next = cand_reg + 1'b1;
                    end
                end else if (depth_reg == '0) begin
                    // Every placement of the first row has been tried.
                    done_next    = 1'b1;
                    state_next   = ST_EMIT;
                    m_valid_next = 1'b1;
                    m_row_next   = '0;
                    m_col_next   = '0;
                    m_last_next  = 1'b1;
                    m_exh_next   = 1'b1;
                end else begin
                    // Backtrack one row.
                    pop        = 1'b1;
                    depth_next = depth_reg - 1'b1;
                    cand_next  = {1'b0, top_col} + 1'b1;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (m_last_reg) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        m_row_next  = m_row_reg + 1'b1;
                        m_col_next  = sel_col;
                        m_last_next = (({1'b0, m_row_reg} + SIZE_W'(2)) == n_eff);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new board size abandons the current search.
        if (cfg_wr_en) begin
            board_size_next = cfg_wr_data;
            depth_next      = '0;
            started_next    = 1'b0;
            done_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            board_size_reg <= RESET_SIZE;
            depth_reg      <= '0;
            cand_reg       <= '0;
            started_reg    <= 1'b0;
            done_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            board_size_reg <= board_size_next;
            depth_reg      <= depth_next;
            cand_reg       <= cand_next;
            started_reg    <= started_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
        end
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_last_reg <= m_last_next;
        m_exh_reg  <= m_exh_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_row_index    = m_row_reg;
    assign m_queen_column = m_col_reg;
    assign m_last_row     = m_last_reg;
    assign m_exhausted    = m_exh_reg;

    // A result is shown only while the block is emitting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == ST_EMIT))
        else $error("result valid outside the emit state");

    // Never more queens on the stack than it has cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= MAX_N)
        else $error("search depth beyond stack length");

    // The exhausted result is a single, final row with zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_exhausted) |-> (m_last_row && m_row_index == '0 && m_queen_column == '0))
        else $error("malformed exhausted item");

    // After the last row is taken the block is ready for a new item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_row) |=> s_ready)
        else $error("block not idle after the final row");

endmodule

/* hdl/nq_cell.sv */
`timescale 1ns / 1ps

module nq_cell import nq_pkg::*; #(
    parameter int DIST = 1
) (
    input  logic             aclk,
    input  nq_ctrl_t         ctrl,
    input  logic [COL_W-1:0] prev_col,
    input  logic [COL_W-1:0] next_col,
    input  logic             conflict_in,
    output logic [COL_W-1:0] col,
    output logic             conflict_out
);

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              active;
    logic [SIZE_W-1:0] col_ext;
    logic [SIZE_W-1:0] diff;
    logic              hit;

    // This cell holds the queen placed DIST rows above the row being tried.
    assign active  = (ctrl.depth >= SIZE_W'(DIST));
    assign col_ext = {1'b0, col_reg};
    assign diff    = (col_ext >= ctrl.cand) ? (col_ext - ctrl.cand) : (ctrl.cand - col_ext);
    assign hit     = (diff == '0) || (diff == SIZE_W'(DIST));

    // The attack flag ripples along the chain from the top of the stack.
    assign conflict_out = conflict_in | (active & hit);
    assign col          = col_reg;

    // A push moves every entry one place deeper; a pop pulls them back.
    always_comb begin
        col_next = col_reg;
        if (ctrl.push) begin
            col_next = prev_col;
        end else if (ctrl.pop) begin
            col_next = next_col;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

endmodule
